// ===== hw/rtl/rle_pkg.sv =====
// Shared types and constants of the run-length byte encoder.
`default_nettype none

package rle_pkg;

  localparam logic [7:0] DIGIT_ZERO  = 8'h30;
  localparam logic [3:0] LIMIT_LOW   = 4'd2;
  localparam logic [3:0] LIMIT_HIGH  = 4'd9;
  localparam logic [3:0] MAX_RUN_RST = 4'd9;

  // One encoded pair: a count digit followed by the run byte.
  typedef struct packed {
    logic [3:0] count;
    logic [7:0] data;
  } pair_t;

  // Everything that one input item produces: one or two pairs.
  typedef struct packed {
    pair_t p0;
    pair_t p1;
    logic  two;
    logic  last;
  } rec_t;

  function automatic logic [7:0] count_digit(input logic [3:0] count);
    count_digit = DIGIT_ZERO + {4'd0, count};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rle_core.sv =====
// Run state and the single-pass encode of one registered input byte.
`default_nettype none

module rle_core
  import rle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr,
  input  wire logic [3:0] cfg_data,
  input  wire logic       item_vld,
  input  wire logic [7:0] item_byte,
  input  wire logic       item_last,
  input  wire logic       load_rdy,
  output rec_t            rec,
  output logic            rec_vld
);

  logic [3:0] max_run_r;
  logic [7:0] run_byte_r, run_byte_nxt;
  logic [3:0] run_count_r, run_count_nxt;
  logic       in_msg_r, in_msg_nxt;

  logic [3:0] lim;
  logic [3:0] cnt_inc;
  logic [7:0] nb;
  logic [3:0] nc;
  logic       a_vld, b_vld;
  pair_t      pa, pb;
  logic       step;

  always_comb begin
    if (max_run_r < LIMIT_LOW) begin
      lim = LIMIT_LOW;
    end else if (max_run_r > LIMIT_HIGH) begin
      lim = LIMIT_HIGH;
    end else begin
      lim = max_run_r;
    end
  end

  assign cnt_inc = run_count_r + 4'd1;

  always_comb begin
    a_vld      = 1'b0;
    pa.count   = run_count_r;
    pa.data    = run_byte_r;
    nb         = item_byte;
    nc         = 4'd1;
    if (!in_msg_r) begin
      a_vld = 1'b0;
    end else if (item_byte == run_byte_r) begin
      nb = run_byte_r;
      if (cnt_inc >= lim) begin
        a_vld    = 1'b1;
        pa.count = cnt_inc;
        nc       = 4'd0;
      end else begin
        nc = cnt_inc;
      end
    end else begin
      // A byte that breaks the run flushes whatever is still pending.
      a_vld = (run_count_r != 4'd0);
    end

    b_vld    = item_last && (nc != 4'd0);
    pb.count = nc;
    pb.data  = nb;

    if (item_last) begin
      run_byte_nxt  = 8'd0;
      run_count_nxt = 4'd0;
      in_msg_nxt    = 1'b0;
    end else begin
      run_byte_nxt  = nb;
      run_count_nxt = nc;
      in_msg_nxt    = 1'b1;
    end
  end

  // Pack the pairs so that the first valid one always sits in p0.
  always_comb begin
    rec.p0   = a_vld ? pa : pb;
    rec.p1   = pb;
    rec.two  = a_vld && b_vld;
    rec.last = item_last;
  end

  assign rec_vld = item_vld && (a_vld || b_vld);
  assign step    = item_vld && load_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_run_r   <= MAX_RUN_RST;
      run_byte_r  <= 8'd0;
      run_count_r <= 4'd0;
      in_msg_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        max_run_r <= cfg_data;
      end
      if (step) begin
        run_byte_r  <= run_byte_nxt;
        run_count_r <= run_count_nxt;
        in_msg_r    <= in_msg_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rle_out_ser.sv =====
// Result register that sends the digit and byte of each pair one beat at a time.
`default_nettype none

module rle_out_ser
  import rle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire rec_t       rec,
  input  wire logic       rec_vld,
  output logic            load_rdy,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  rec_t       cur_r;
  logic       cur_vld_r;
  logic [1:0] pos_r;
  pair_t      sel;
  logic       final_beat;
  logic       beat;

  // pos_r[1] picks the pair, pos_r[0] picks digit or run byte.
  assign sel        = pos_r[1] ? cur_r.p1 : cur_r.p0;
  assign final_beat = pos_r[0] && (pos_r[1] == cur_r.two);
  assign beat       = cur_vld_r && !out_stall;

  assign out_valid = cur_vld_r;
  assign out_byte  = pos_r[0] ? sel.data : count_digit(sel.count);
  assign out_last  = cur_r.last && final_beat;
  assign load_rdy  = !cur_vld_r || (beat && final_beat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      pos_r     <= 2'd0;
    end else begin
      if (load_rdy) begin
        cur_vld_r <= rec_vld;
        pos_r     <= 2'd0;
      end else if (beat) begin
        pos_r <= pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_rdy && rec_vld) begin
      cur_r <= rec;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rle_byte_encoder.sv =====
// Top level of the streaming run-length byte encoder.
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  in_data_byte[7:0], in_is_last
//  out_     output     out_valid/out_stall out_byte[7:0], out_last
//  cfg_     input      cfg_valid/cfg_ready cfg_max_run[3:0]
//
// An input byte is registered, then encoded combinationally into zero, two or
// four beats that load into the result register and leave from there. One beat
// goes out a cycle while out_stall is low, and the next item loads on the edge
// of the last beat, so the result register takes no new item before its last
// beat is out; an item that makes no beats still waits for that, then loads empty.
// Reset clears the run state and sets max_run to 9. A stall on the output
// side holds the result register and, once it is needed, the input register.
`default_nettype none

module rle_byte_encoder
  import rle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_is_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_max_run
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       load_rdy;
  rec_t       rec;
  logic       rec_vld;

  assign cfg_ready = 1'b1;
  assign in_stall  = in_vld_r && !load_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_is_last;
    end
  end

  rle_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_max_run),
    .item_vld  (in_vld_r),
    .item_byte (in_byte_r),
    .item_last (in_last_r),
    .load_rdy  (load_rdy),
    .rec       (rec),
    .rec_vld   (rec_vld)
  );

  rle_out_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec       (rec),
    .rec_vld   (rec_vld),
    .load_rdy  (load_rdy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with an empty input register");

  a_first_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    rec_vld && load_rdy |-> (rec.p0.count != 4'd0) && (rec.p0.count <= LIMIT_HIGH))
    else $error("first pair count outside one to nine");

  a_second_pair_flush: assert property (@(posedge clk) disable iff (!rst_n)
    rec_vld && rec.two |-> rec.last && (rec.p1.count != 4'd0))
    else $error("second pair without a flush or with zero count");
`endif

endmodule

`default_nettype wire
